// File: hdl/joystick_axis_calibrate_map_assert.svh
// Assertion macros shared by the joystick calibration checker.
`ifndef JOYSTICK_AXIS_CALIBRATE_MAP_ASSERT_SVH
`define JOYSTICK_AXIS_CALIBRATE_MAP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define JACM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define JACM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/jacm_pkg.sv
// Package with the shared types and constants of the joystick calibration block.
`timescale 1ns / 1ps
`default_nettype none

package jacm_pkg;

  // Default widths of a converter sample and of the fraction of a position.
  localparam int SAMPLE_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF   = 15;

  // Deadzone value after reset.
  localparam int DEADZONE_RESET = 64;

  // Configuration port geometry and register map.
  localparam int CFG_ADDR_BITS = 2;
  localparam int CFG_DATA_BITS = 32;
  localparam logic [CFG_ADDR_BITS-1:0] REG_DEADZONE = 2'd0;

  // Request opcodes.
  typedef enum logic [2:0] {
    OP_MAP        = 3'd0,
    OP_CAL_START  = 3'd1,
    OP_CAL_SAMPLE = 3'd2,
    OP_CENTER     = 3'd3,
    OP_CAL_END    = 3'd4
  } op_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_DONE
  } state_t;

  // Controls from the sequencer to both axis lanes.
  typedef struct packed {
    logic prep;
    logic step;
  } lane_ctrl_t;

endpackage

`default_nettype wire

// File: hdl/jacm_lane.sv
// One axis lane: calibration state, span selection and a restoring divider.
`timescale 1ns / 1ps
`default_nettype none

module jacm_lane #(
  parameter int SAMPLE_BITS = jacm_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = jacm_pkg::FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  jacm_pkg::lane_ctrl_t   ctrl,
  input  logic [2:0]             op,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic [SAMPLE_BITS-1:0] deadzone,
  input  logic                   cal_active,
  output logic [FRAC_BITS:0]     pos
);

  localparam int S = SAMPLE_BITS;
  localparam int F = FRAC_BITS;
  localparam logic [S-1:0] MID_SCALE = {1'b0, {(S-1){1'b1}}};
  localparam logic [S-1:0] FULL_SCALE = {S{1'b1}};
  localparam logic [F-1:0] ONE_Q = {F{1'b1}};

  // Calibration state of this axis.
  logic [S-1:0] center;
  logic [S-1:0] low;
  logic [S-1:0] high;

  // Divider and result flags.
  logic [S-1:0] rem;
  logic [F-1:0] qd;
  logic [S-1:0] den;
  logic         neg;
  logic         zero;
  logic         sat;

  // Span selection signals.
  logic [S-1:0]   delta;
  logic           in_zone;
  logic [S-1:0]   s_raised;
  logic [S-1:0]   s_clamped;
  logic           upper;
  logic [S-1:0]   num;
  logic [S-1:0]   den_sel;
  logic           no_span;
  logic [S+F-1:0] dividend;

  // Divider step signals.
  logic [S:0]   trial;
  logic [S:0]   diff;
  logic         fits;
  logic [F-1:0] mag;
  logic [F:0]   mag_ext;

  // Distance to centre, clamping and choice of the half-span that applies.
  always_comb begin
    delta     = (sample >= center) ? (sample - center) : (center - sample);
    in_zone   = (delta <= deadzone);
    s_raised  = (sample < low) ? low : sample;
    s_clamped = (s_raised > high) ? high : s_raised;
    upper     = (s_clamped >= center);
    if (upper) begin
      num     = s_clamped - center;
      den_sel = high - center;
      no_span = (high <= center);
    end else begin
      num     = center - s_clamped;
      den_sel = center - low;
      no_span = (center <= low);
    end
    // Multiplying by the all-ones fraction is a shift and a subtraction.
    dividend = {num, {F{1'b0}}} - {{F{1'b0}}, num};
  end

  // One restoring division step: the next dividend bit enters at the bottom of the remainder.
  always_comb begin
    trial = {rem, qd[F-1]};
    diff  = trial - {1'b0, den};
    fits  = (trial >= {1'b0, den});
  end

  // Calibration state updates, taken in the preparation cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      center <= MID_SCALE;
      low    <= '0;
      high   <= FULL_SCALE;
    end else if (ctrl.prep) begin
      case (op)
        jacm_pkg::OP_CAL_START: begin
          if (!cal_active) begin
            low  <= MID_SCALE;
            high <= MID_SCALE;
          end
        end
        jacm_pkg::OP_CAL_SAMPLE: begin
          if (cal_active) begin
            if (sample > high) high <= sample;
            if (sample < low) low <= sample;
          end
        end
        jacm_pkg::OP_CENTER: begin
          if (!cal_active) center <= sample;
        end
        default: begin
        end
      endcase
    end
  end

  // Divider load and iteration; a full quotient would reach one, so that case saturates.
  always_ff @(posedge clk) begin
    if (ctrl.prep) begin
      rem  <= dividend[S+F-1:F];
      qd   <= dividend[F-1:0];
      den  <= den_sel;
      neg  <= !upper;
      zero <= (op != jacm_pkg::OP_MAP) || in_zone || no_span;
      sat  <= (num >= den_sel);
    end else if (ctrl.step) begin
      rem <= fits ? diff[S-1:0] : trial[S-1:0];
      qd  <= {qd[F-2:0], fits};
    end
  end

  // Signed position from the magnitude.
  always_comb begin
    if (zero) begin
      mag = '0;
    end else if (sat) begin
      mag = ONE_Q;
    end else begin
      mag = qd;
    end
    mag_ext = {1'b0, mag};
    pos     = neg ? (~mag_ext + 1'b1) : mag_ext;
  end

endmodule

`default_nettype wire

// File: hdl/jacm_merge.sv
// Result stage that joins the two lane positions and the calibration flag.
`timescale 1ns / 1ps
`default_nettype none

module jacm_merge #(
  parameter int FRAC_BITS = jacm_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  logic [FRAC_BITS:0]    x_lane,
  input  logic [FRAC_BITS:0]    y_lane,
  input  logic                  cal,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic signed [FRAC_BITS:0] x_pos,
  output logic signed [FRAC_BITS:0] y_pos,
  output logic                  calibrating,
  output logic                  free
);

  // The register may take a new result when empty or being emptied.
  assign free = !out_valid || out_ready;

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (load) begin
      x_pos       <= x_lane;
      y_pos       <= y_lane;
      calibrating <= cal;
    end
  end

endmodule

`default_nettype wire

// File: hdl/joystick_axis_calibrate_map.sv
// Top level of the joystick axis calibration and mapping block.
`timescale 1ns / 1ps
`default_nettype none

// Each request carries an opcode and one X and one Y sample; both axes are
// handled at once by two identical lanes, and every request yields exactly one
// result. After the edge that accepts the request, the sequencer steps through
// a preparation state that selects the span and updates the calibration state,
// a divide state in which the restoring divider of each lane produces one
// quotient bit per cycle, and a done state that loads the output register.
// The block is ready again in the cycle after that load and takes no new
// request before then.
// The next request is accepted even if the previous result has not yet been
// taken; its own result then waits in the done state until the output register
// is free, and the block takes nothing new meanwhile. The deadzone register
// sits at byte address 0 of the configuration port and resets to 64.
module joystick_axis_calibrate_map #(
  parameter int SAMPLE_BITS = jacm_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = jacm_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [2:0]                         opcode,
  input  logic [SAMPLE_BITS-1:0]             x_sample,
  input  logic [SAMPLE_BITS-1:0]             y_sample,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [FRAC_BITS:0]          x_pos,
  output logic signed [FRAC_BITS:0]          y_pos,
  output logic                               calibrating,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [jacm_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  logic [jacm_pkg::CFG_DATA_BITS-1:0] pwdata,
  output logic [jacm_pkg::CFG_DATA_BITS-1:0] prdata,
  output logic                               pready
);

  localparam int CNT_BITS = $clog2(FRAC_BITS);
  localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(FRAC_BITS - 1);

  jacm_pkg::state_t     state;
  jacm_pkg::state_t     state_next;
  jacm_pkg::lane_ctrl_t ctrl;

  logic [2:0]             op;
  logic [SAMPLE_BITS-1:0] x_q;
  logic [SAMPLE_BITS-1:0] y_q;
  logic [CNT_BITS-1:0]    cnt;
  logic                   cal_active;
  logic [SAMPLE_BITS-1:0] deadzone;
  logic                   merge_load;
  logic                   merge_free;
  logic [FRAC_BITS:0]     x_lane;
  logic [FRAC_BITS:0]     y_lane;

  // Configuration port: zero wait states, deadzone is the only register.
  assign pready = 1'b1;

  always_comb begin
    if (paddr == jacm_pkg::REG_DEADZONE) begin
      prdata = {{(jacm_pkg::CFG_DATA_BITS-SAMPLE_BITS){1'b0}}, deadzone};
    end else begin
      prdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      deadzone <= SAMPLE_BITS'(jacm_pkg::DEADZONE_RESET);
    end else if (psel && penable && pwrite && pready
                 && paddr == jacm_pkg::REG_DEADZONE) begin
      deadzone <= pwdata[SAMPLE_BITS-1:0];
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= jacm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: accept, prepare, divide, hand over to the result stage.
  always_comb begin
    state_next = state;
    ctrl       = '0;
    in_ready   = 1'b0;
    merge_load = 1'b0;
    unique case (state)
      jacm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = jacm_pkg::ST_PREP;
      end
      jacm_pkg::ST_PREP: begin
        ctrl.prep  = 1'b1;
        state_next = jacm_pkg::ST_DIV;
      end
      jacm_pkg::ST_DIV: begin
        ctrl.step = 1'b1;
        if (cnt == CNT_LAST) state_next = jacm_pkg::ST_DONE;
      end
      jacm_pkg::ST_DONE: begin
        if (merge_free) begin
          merge_load = 1'b1;
          state_next = jacm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = jacm_pkg::ST_IDLE;
      end
    endcase
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op  <= opcode;
      x_q <= x_sample;
      y_q <= y_sample;
    end
  end

  // Divider step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ctrl.prep) begin
      cnt <= '0;
    end else if (ctrl.step) begin
      cnt <= cnt + 1'b1;
    end
  end

  // Range calibration flag, shared by both lanes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cal_active <= 1'b0;
    end else if (ctrl.prep) begin
      if (op == jacm_pkg::OP_CAL_START) begin
        cal_active <= 1'b1;
      end else if (op == jacm_pkg::OP_CAL_END) begin
        cal_active <= 1'b0;
      end
    end
  end

  // Axis lanes.
  jacm_lane #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_lane_x (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .op        (op),
    .sample    (x_q),
    .deadzone  (deadzone),
    .cal_active(cal_active),
    .pos       (x_lane)
  );

  jacm_lane #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_lane_y (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .op        (op),
    .sample    (y_q),
    .deadzone  (deadzone),
    .cal_active(cal_active),
    .pos       (y_lane)
  );

  // Result stage.
  jacm_merge #(
    .FRAC_BITS(FRAC_BITS)
  ) u_merge (
    .clk        (clk),
    .rst        (rst),
    .load       (merge_load),
    .x_lane     (x_lane),
    .y_lane     (y_lane),
    .cal        (cal_active),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .x_pos      (x_pos),
    .y_pos      (y_pos),
    .calibrating(calibrating),
    .free       (merge_free)
  );

endmodule

`default_nettype wire

// File: hdl/jacm_checker.sv
// Port-level checker for the joystick calibration block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "joystick_axis_calibrate_map_assert.svh"

module jacm_checker #(
  parameter int FRAC_BITS = jacm_pkg::FRAC_BITS_DEF
) (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic signed [FRAC_BITS:0] x_pos,
  input logic signed [FRAC_BITS:0] y_pos,
  input logic                      calibrating
);

  localparam logic [FRAC_BITS:0] POS_MIN = {1'b1, {FRAC_BITS{1'b0}}};

  // A stalled result keeps its payload.
  `JACM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(x_pos) && $stable(y_pos) && $stable(calibrating), "stalled result changed")

  // Work on one request at a time: no back-to-back acceptance.
  `JACM_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "request accepted while busy")

  // Positions are symmetric and never reach the most negative code.
  `JACM_ASSERT_NOW(a_x_range, out_valid, x_pos != POS_MIN, "x_pos out of range")
  `JACM_ASSERT_NOW(a_y_range, out_valid, y_pos != POS_MIN, "y_pos out of range")

endmodule

bind joystick_axis_calibrate_map jacm_checker #(
  .FRAC_BITS(FRAC_BITS)
) u_jacm_checker (.*);

`default_nettype wire

// File: verif/joystick_axis_calibrate_map_test.sv
// Self-checking testbench for the joystick axis calibration and mapping block.
`timescale 1ns / 1ps

module joystick_axis_calibrate_map_test;

  localparam int SAMPLE_W       = jacm_pkg::SAMPLE_BITS_DEF;
  localparam int FRAC_W         = jacm_pkg::FRAC_BITS_DEF;
  localparam int SAMPLE_MAX     = (1 << SAMPLE_W) - 1;
  localparam int MID_SCALE      = SAMPLE_MAX / 2;
  localparam int POS_ONE        = (1 << FRAC_W) - 1;
  localparam int PHASES         = 6;
  localparam int PHASE_REQUESTS = 340;
  localparam int END_PAUSE      = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 30;

  // Opcodes that the block defines no action for.
  localparam logic [2:0] OP_SPARE_5 = 3'd5;
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  typedef logic signed [FRAC_W:0] position_t;

  typedef struct packed {
    position_t x_pos;
    position_t y_pos;
    logic      calibrating;
  } axis_result_t;

  typedef struct packed {
    logic [2:0]          op;
    logic [SAMPLE_W-1:0] x;
    logic [SAMPLE_W-1:0] y;
    logic                typed;
    axis_result_t        want;
  } directed_row_t;

  localparam axis_result_t FROM_PREDICTOR  = '0;
  localparam axis_result_t CENTRED_IDLE    = '{16'sd0, 16'sd0, 1'b0};
  localparam axis_result_t CENTRED_RANGING = '{16'sd0, 16'sd0, 1'b1};

  // Directed requests; the result is typed in where it is plain from the rules.
  localparam int DIRECTED_ROWS = 24;
  localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{jacm_pkg::OP_MAP,        12'd2047, 12'd2047, 1'b1, CENTRED_IDLE},
    '{jacm_pkg::OP_MAP,        12'd4095, 12'd0,    1'b1, '{16'sd32767, -16'sd32767, 1'b0}},
    '{jacm_pkg::OP_MAP,        12'd2111, 12'd1983, 1'b1, CENTRED_IDLE},
    '{jacm_pkg::OP_MAP,        12'd2112, 12'd1982, 1'b0, FROM_PREDICTOR},
    '{jacm_pkg::OP_MAP,        12'd0,    12'd4095, 1'b1, '{-16'sd32767, 16'sd32767, 1'b0}},
    '{OP_SPARE_5,              12'd4095, 12'd4095, 1'b1, CENTRED_IDLE},
    '{OP_SPARE_6,              12'd0,    12'd0,    1'b1, CENTRED_IDLE},
    '{OP_SPARE_7,              12'd4095, 12'd0,    1'b1, CENTRED_IDLE},
    '{jacm_pkg::OP_CAL_END,    12'd1234, 12'd2345, 1'b1, CENTRED_IDLE},
    '{jacm_pkg::OP_CAL_SAMPLE, 12'd0,    12'd4095, 1'b1, CENTRED_IDLE},
    '{jacm_pkg::OP_MAP,        12'd0,    12'd4095, 1'b1, '{-16'sd32767, 16'sd32767, 1'b0}},
    '{jacm_pkg::OP_CAL_START,  12'd0,    12'd0,    1'b1, CENTRED_RANGING},
    '{jacm_pkg::OP_MAP,        12'd4095, 12'd0,    1'b1, CENTRED_RANGING},
    '{jacm_pkg::OP_CAL_START,  12'd4095, 12'd4095, 1'b1, CENTRED_RANGING},
    '{jacm_pkg::OP_CENTER,     12'd100,  12'd100,  1'b1, CENTRED_RANGING},
    '{jacm_pkg::OP_CAL_SAMPLE, 12'd3000, 12'd1000, 1'b1, CENTRED_RANGING},
    '{jacm_pkg::OP_CAL_SAMPLE, 12'd1500, 12'd3500, 1'b1, CENTRED_RANGING},
    '{jacm_pkg::OP_MAP,        12'd4095, 12'd0,    1'b1, '{16'sd32767, -16'sd32767, 1'b1}},
    '{jacm_pkg::OP_MAP,        12'd2500, 12'd1500, 1'b0, FROM_PREDICTOR},
    '{jacm_pkg::OP_CAL_END,    12'd0,    12'd0,    1'b1, CENTRED_IDLE},
    '{jacm_pkg::OP_CENTER,     12'd0,    12'd4095, 1'b1, CENTRED_IDLE},
    '{jacm_pkg::OP_MAP,        12'd4095, 12'd0,    1'b1, '{16'sd32767, -16'sd32767, 1'b0}},
    '{jacm_pkg::OP_MAP,        12'd1234, 12'd2345, 1'b0, FROM_PREDICTOR},
    '{jacm_pkg::OP_CENTER,     12'd2047, 12'd2047, 1'b1, CENTRED_IDLE}
  };

  logic                                clk;
  logic                                rst;
  logic                                in_valid;
  logic                                in_ready;
  logic [2:0]                          opcode;
  logic [SAMPLE_W-1:0]                 x_sample;
  logic [SAMPLE_W-1:0]                 y_sample;
  logic                                out_valid;
  logic                                out_ready;
  position_t                           x_pos;
  position_t                           y_pos;
  logic                                calibrating;
  logic                                psel;
  logic                                penable;
  logic                                pwrite;
  logic [jacm_pkg::CFG_ADDR_BITS-1:0]  paddr;
  logic [jacm_pkg::CFG_DATA_BITS-1:0]  pwdata;
  logic [jacm_pkg::CFG_DATA_BITS-1:0]  prdata;
  logic                                pready;

  // Expected result of the request on the input, where the table gives one.
  logic         drive_typed;
  axis_result_t drive_want;

  // Own copy of the calibration state and the deadzone register.
  int   deadzone_cfg;
  int   cal_center_x, cal_center_y;
  int   cal_low_x, cal_high_x, cal_low_y, cal_high_y;
  logic ranging;

  axis_result_t pending_positions[$];
  axis_result_t predicted, arrived, oldest;
  int           mismatches;
  int           requests_issued;
  int           ready_hold;
  int           idle_cycles;
  logic         quiet;

  joystick_axis_calibrate_map dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .opcode      (opcode),
    .x_sample    (x_sample),
    .y_sample    (y_sample),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .x_pos       (x_pos),
    .y_pos       (y_pos),
    .calibrating (calibrating),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #1 clk = ~clk;

  // Position of one axis: zero inside the deadzone, otherwise the clamped
  // sample scaled against the span on its side of center, truncated.
  function automatic position_t axis_position(int s, int cen, int lo, int hi);
    int      delta;
    longint  num, den, mag;
    logic    below;
    delta = (s >= cen) ? s - cen : cen - s;
    if (delta <= deadzone_cfg) return '0;
    if (s < lo) s = lo;
    if (s > hi) s = hi;
    if (s >= cen) begin
      if (hi <= cen) return '0;
      num   = s - cen;
      den   = hi - cen;
      below = 1'b0;
    end else begin
      if (cen <= lo) return '0;
      num   = cen - s;
      den   = cen - lo;
      below = 1'b1;
    end
    mag = num * POS_ONE / den;
    if (mag > POS_ONE) mag = POS_ONE;
    return below ? position_t'(-mag) : position_t'(mag);
  endfunction

  // Applies one request to the calibration state and works out its result.
  function automatic void advance_joystick(input logic [2:0] op, input int sx, input int sy,
                                           output axis_result_t res);
    res = '0;
    case (op)
      jacm_pkg::OP_MAP: begin
        res.x_pos = axis_position(sx, cal_center_x, cal_low_x, cal_high_x);
        res.y_pos = axis_position(sy, cal_center_y, cal_low_y, cal_high_y);
      end
      jacm_pkg::OP_CAL_START: begin
        if (!ranging) begin
          cal_low_x  = MID_SCALE;
          cal_high_x = MID_SCALE;
          cal_low_y  = MID_SCALE;
          cal_high_y = MID_SCALE;
          ranging    = 1'b1;
        end
      end
      jacm_pkg::OP_CAL_SAMPLE: begin
        if (ranging) begin
          if (sx > cal_high_x) cal_high_x = sx;
          if (sx < cal_low_x) cal_low_x = sx;
          if (sy > cal_high_y) cal_high_y = sy;
          if (sy < cal_low_y) cal_low_y = sy;
        end
      end
      jacm_pkg::OP_CENTER: begin
        if (!ranging) begin
          cal_center_x = sx;
          cal_center_y = sy;
        end
      end
      jacm_pkg::OP_CAL_END: begin
        ranging = 1'b0;
      end
      default: begin
      end
    endcase
    res.calibrating = ranging;
  endfunction

  // Mostly no gap, sometimes a short one, now and then a long one.
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [SAMPLE_W-1:0] clamp_sample(int v);
    if (v < 0) return '0;
    if (v > SAMPLE_MAX) return SAMPLE_W'(SAMPLE_MAX);
    return SAMPLE_W'(v);
  endfunction

  // Sample for mapping: random, on the deadzone edge, at the rails or near center.
  function automatic logic [SAMPLE_W-1:0] map_sample(int cen);
    int r, off;
    r = $urandom_range(0, 99);
    if (r < 40) return SAMPLE_W'($urandom);
    if (r < 70) begin
      off = deadzone_cfg + $urandom_range(0, 3) - 1;
      return clamp_sample($urandom_range(0, 1) ? cen + off : cen - off);
    end
    if (r < 85) return $urandom_range(0, 1) ? SAMPLE_W'(SAMPLE_MAX) : '0;
    return clamp_sample(cen + $urandom_range(0, 8) - 4);
  endfunction

  // Sample around midscale, from spread below it to spread plus one above it.
  function automatic logic [SAMPLE_W-1:0] spread_sample(int spread);
    return clamp_sample(MID_SCALE - spread + int'($urandom_range(0, 2 * spread + 1)));
  endfunction

  // Offers one request and holds it until the block takes it.
  task automatic send_request(input logic [2:0] op, input logic [SAMPLE_W-1:0] sx,
                              input logic [SAMPLE_W-1:0] sy, input logic typed,
                              input axis_result_t want);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    opcode      <= op;
    x_sample    <= sx;
    y_sample    <= sy;
    drive_typed <= typed;
    drive_want  <= want;
    do @(posedge clk); while (!in_ready);
    requests_issued++;
    @(negedge clk);
  endtask

  // Writes the deadzone register, then reads it back.
  task automatic write_deadzone(input int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= jacm_pkg::REG_DEADZONE;
    pwdata  <= jacm_pkg::CFG_DATA_BITS'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    deadzone_cfg = value & SAMPLE_MAX;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== jacm_pkg::CFG_DATA_BITS'(deadzone_cfg)) begin
      if (mismatches < MAX_REPORTS)
        $error("deadzone: expected %0d, actual %0d", deadzone_cfg, prdata);
      mismatches++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Stops offering and waits until every expected result has been taken.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_positions.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // One random step: a map, a calibration run, a center capture or noise.
  task automatic random_step();
    int r, n, k, spread;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      send_request(jacm_pkg::OP_MAP, map_sample(cal_center_x), map_sample(cal_center_y),
                   1'b0, FROM_PREDICTOR);
    end else if (r < 72) begin
      send_request(jacm_pkg::OP_CAL_START, SAMPLE_W'($urandom), SAMPLE_W'($urandom),
                   1'b0, FROM_PREDICTOR);
      n      = $urandom_range(1, 6);
      spread = MID_SCALE >> $urandom_range(0, 10);
      for (k = 0; k < n; k++) begin
        if ($urandom_range(0, 3) == 0)
          send_request(jacm_pkg::OP_MAP, map_sample(cal_center_x),
                       map_sample(cal_center_y), 1'b0, FROM_PREDICTOR);
        else
          send_request(jacm_pkg::OP_CAL_SAMPLE, spread_sample(spread),
                       spread_sample(spread), 1'b0, FROM_PREDICTOR);
      end
      // A run is now and then left open, so later requests meet an active calibration.
      if ($urandom_range(0, 9) != 0)
        send_request(jacm_pkg::OP_CAL_END, SAMPLE_W'($urandom), SAMPLE_W'($urandom),
                     1'b0, FROM_PREDICTOR);
    end else if (r < 82) begin
      spread = $urandom_range(0, 3) == 0 ? MID_SCALE : 400;
      send_request(jacm_pkg::OP_CENTER, spread_sample(spread), spread_sample(spread),
                   1'b0, FROM_PREDICTOR);
    end else begin
      send_request(3'($urandom), SAMPLE_W'($urandom), SAMPLE_W'($urandom),
                   1'b0, FROM_PREDICTOR);
    end
  endtask

  // Receiver side: random stalls on the result channel.
  always @(negedge clk) begin
    if (ready_hold > 0) begin
      ready_hold--;
      out_ready <= 1'b0;
    end else begin
      ready_hold = idle_gap();
      out_ready <= (ready_hold == 0);
    end
  end

  // Predicts each accepted request and checks each accepted result.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        arrived = '{x_pos, y_pos, calibrating};
        if (pending_positions.size() == 0) begin
          if (mismatches < MAX_REPORTS)
            $error("result with nothing expected: x_pos %0d y_pos %0d calibrating %0b",
                   x_pos, y_pos, calibrating);
          mismatches++;
        end else begin
          oldest = pending_positions.pop_front();
          if (arrived.x_pos !== oldest.x_pos) begin
            if (mismatches < MAX_REPORTS)
              $error("x_pos: expected %0d, actual %0d", oldest.x_pos, arrived.x_pos);
            mismatches++;
          end
          if (arrived.y_pos !== oldest.y_pos) begin
            if (mismatches < MAX_REPORTS)
              $error("y_pos: expected %0d, actual %0d", oldest.y_pos, arrived.y_pos);
            mismatches++;
          end
          if (arrived.calibrating !== oldest.calibrating) begin
            if (mismatches < MAX_REPORTS)
              $error("calibrating: expected %0b, actual %0b", oldest.calibrating,
                     arrived.calibrating);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        advance_joystick(opcode, x_sample, y_sample, predicted);
        pending_positions.push_back(drive_typed ? drive_want : predicted);
      end
    end
  end

  // Ends the run if nothing moves on any port for too long.
  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
          (psel && penable && pready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  // Main sequence: directed table, then random phases under several deadzones.
  initial begin
    int row;
    int phase;
    int dz;
    clk             = 1'b0;
    rst             = 1'b1;
    in_valid        = 1'b0;
    opcode          = jacm_pkg::OP_MAP;
    x_sample        = '0;
    y_sample        = '0;
    out_ready       = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = jacm_pkg::REG_DEADZONE;
    pwdata          = '0;
    drive_typed     = 1'b0;
    drive_want      = '0;
    quiet           = 1'b0;
    ready_hold      = 0;
    mismatches      = 0;
    requests_issued = 0;
    deadzone_cfg    = jacm_pkg::DEADZONE_RESET;
    cal_center_x    = MID_SCALE;
    cal_center_y    = MID_SCALE;
    cal_low_x       = 0;
    cal_high_x      = SAMPLE_MAX;
    cal_low_y       = 0;
    cal_high_y      = SAMPLE_MAX;
    ranging         = 1'b0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_deadzone(jacm_pkg::DEADZONE_RESET);
    for (row = 0; row < DIRECTED_ROWS; row++)
      send_request(DIRECTED[row].op, DIRECTED[row].x, DIRECTED[row].y,
                   DIRECTED[row].typed, DIRECTED[row].want);
    drain_results();

    // Each phase starts from an idle block; one phase runs without any gaps.
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       dz = 0;
        1:       dz = SAMPLE_MAX;
        2:       dz = jacm_pkg::DEADZONE_RESET;
        3:       dz = $urandom_range(0, SAMPLE_MAX);
        default: dz = $urandom_range(0, 255);
      endcase
      quiet = (phase == 2);
      write_deadzone(dz);
      requests_issued = 0;
      while (requests_issued < PHASE_REQUESTS) random_step();
      drain_results();
    end

    repeat (END_PAUSE) @(posedge clk);
    if (mismatches == 0 && pending_positions.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// File: files.f
+incdir+hdl
hdl/jacm_pkg.sv
hdl/jacm_lane.sv
hdl/jacm_merge.sv
hdl/joystick_axis_calibrate_map.sv
hdl/jacm_checker.sv
verif/joystick_axis_calibrate_map_test.sv
